### hw/rtl/udpc_pkg.sv
// Shared types and constants of the doorway people counter.
package udpc_pkg;

   localparam int unsigned DIST_MUL   = 4456;
   localparam int unsigned DIST_SHIFT = 10;
   localparam int unsigned ECHO_W     = 16;
   localparam int unsigned DIST_W     = 19;
   localparam int unsigned REG_W      = 16;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [REG_W-1:0] HIST_RESET = 16'd3840;

   localparam logic signed [15:0] OCC_MAX = 16'sh7FFF;
   localparam logic signed [15:0] OCC_MIN = -16'sh8000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_VALID_MIN    = 3'd0,
      CSR_VALID_MAX    = 3'd1,
      CSR_FAR_LOW      = 3'd2,
      CSR_FAR_HIGH     = 3'd3,
      CSR_NEAR_LOW     = 3'd4,
      CSR_NEAR_HIGH    = 3'd5,
      CSR_REFILL_VALUE = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTER = 2'd1,
      EV_LEFT  = 2'd2,
      EV_RANGE = 2'd3
   } event_res_type;

   typedef struct packed {
      logic [REG_W-1:0] valid_min;
      logic [REG_W-1:0] valid_max;
      logic [REG_W-1:0] far_low;
      logic [REG_W-1:0] far_high;
      logic [REG_W-1:0] near_low;
      logic [REG_W-1:0] near_high;
      logic [REG_W-1:0] refill_value;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] people_count;
      event_res_type      event_res;
      logic [DIST_W-1:0]  distance_q;
   } result_type;

endpackage

### hw/rtl/ultrasonic_doorway_people_counter_top.sv
// Top level of the ultrasonic doorway people counter.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  req     | in        | req_tvalid/tready  | tdata[15:0] echo_us
//  rsp     | out       | rsp_tvalid/tready  | tdata people_count, distance_q; tuser event
//  csr     | in        | csr_we             | csr_addr register index, csr_wdata value
//
//  Pipeline: a request passes through the echo register, the distance
//  register (after the multiplier) and the result register (after the
//  history and band logic), from which the result is offered.
//  Throughput: one request per cycle while the result is taken; the history
//  and count update closes through running half sums.
//  Reset: synchronous, active high; clears the pipeline valids and the count,
//  loads the history (every entry 3840) with matching sums, registers to defaults.
//  Stalls: a held result only stops the stages behind it when they are full;
//  empty stages keep taking requests.
module ultrasonic_doorway_people_counter_top
   import udpc_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = 20
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] echo_us
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // [15:0] people_count, [34:16] distance_q
   output logic [1:0]            rsp_tuser,   // [1:0] event_res
   // register write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   cfg_type           cfg_ff;
   logic              a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic [ECHO_W-1:0] a_echo_ff;
   logic [DIST_W-1:0] b_dist_ff, dist_calc;
   result_type        rsp_ff, result;
   logic              move_out, move_b, move_a, fire;

   // ready ripples back from the result register
   assign move_out   = !rsp_valid_ff || rsp_tready;
   assign move_b     = !b_valid_ff || move_out;
   assign move_a     = !a_valid_ff || move_b;
   assign req_tready = move_a;
   assign fire       = b_valid_ff && move_out;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.valid_min    <= 16'd1280;
         cfg_ff.valid_max    <= 16'd7680;
         cfg_ff.far_low      <= 16'd4096;
         cfg_ff.far_high     <= 16'd6400;
         cfg_ff.near_low     <= 16'd2048;
         cfg_ff.near_high    <= 16'd3584;
         cfg_ff.refill_value <= 16'd3840;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_VALID_MIN:    cfg_ff.valid_min    <= csr_wdata;
            CSR_VALID_MAX:    cfg_ff.valid_max    <= csr_wdata;
            CSR_FAR_LOW:      cfg_ff.far_low      <= csr_wdata;
            CSR_FAR_HIGH:     cfg_ff.far_high     <= csr_wdata;
            CSR_NEAR_LOW:     cfg_ff.near_low     <= csr_wdata;
            CSR_NEAR_HIGH:    cfg_ff.near_high    <= csr_wdata;
            CSR_REFILL_VALUE: cfg_ff.refill_value <= csr_wdata;
            default: ;  // index beyond the list is dropped
         endcase
      end
   end

   // stage A: echo register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (move_a) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (move_a && req_tvalid) begin
         a_echo_ff <= req_tdata[ECHO_W-1:0];
      end
   end

   udpc_dist u_dist (
      .echo_us    (a_echo_ff),
      .distance_q (dist_calc)
   );

   // stage B: distance register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (move_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move_b && a_valid_ff) begin
         b_dist_ff <= dist_calc;
      end
   end

   // history, band tests and count; state moves only when the request leaves B
   udpc_track #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_track (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .distance_q (b_dist_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move_out) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.distance_q, rsp_ff.people_count};
   assign rsp_tuser  = rsp_ff.event_res;

   // an empty distance stage never holds off a request
   a_ready_when_b_empty : assert property (@(posedge clock) disable iff (reset)
      !b_valid_ff |-> req_tready)
      else $error("request stalled with an empty distance stage");

   // an out of range result really lies outside the accepted window
   a_range_event : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == EV_RANGE) |->
      ((rsp_tdata[34:16] < DIST_W'(cfg_ff.valid_min)) ||
       (rsp_tdata[34:16] > DIST_W'(cfg_ff.valid_max))))
      else $error("range event on an accepted distance");

   // a counted passage only comes from an accepted distance
   a_count_event : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == EV_ENTER || rsp_tuser == EV_LEFT)) |->
      ((rsp_tdata[34:16] >= DIST_W'(cfg_ff.valid_min)) &&
       (rsp_tdata[34:16] <= DIST_W'(cfg_ff.valid_max))))
      else $error("passage counted on a rejected distance");

endmodule

### hw/rtl/udpc_dist.sv
// Echo time to distance conversion, 1/256 cm.
module udpc_dist
   import udpc_pkg::*;
(
   input  logic [ECHO_W-1:0] echo_us,
   output logic [DIST_W-1:0] distance_q
);

   localparam int unsigned PROD_W = ECHO_W + 13;

   logic [PROD_W-1:0] product;

   assign product    = PROD_W'(echo_us) * PROD_W'(DIST_MUL);
   assign distance_q = product[DIST_SHIFT +: DIST_W];

endmodule

### hw/rtl/udpc_track.sv
// Distance history, running half sums, band tests and occupancy count.
module udpc_track
   import udpc_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = 20
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [DIST_W-1:0] distance_q,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam int unsigned HALF  = HISTORY_DEPTH / 2;
   localparam int unsigned SUM_W = REG_W + $clog2(HALF + 1);

   logic [REG_W-1:0]   hist_ff [HISTORY_DEPTH];
   logic [REG_W-1:0]   hist_in [HISTORY_DEPTH];
   logic [SUM_W-1:0]   older_ff, older_in, newer_ff, newer_in;
   logic [SUM_W-1:0]   older_sh, newer_sh, fill_sum;
   logic signed [15:0] occ_ff, occ_in, occ_mid;
   logic [REG_W-1:0]   dist16;
   logic               in_range, enter, leave, leave_shift, leave_fill;
   event_res_type      ev;

   function automatic logic [SUM_W-1:0] times_half(input logic [REG_W-1:0] v);
      return SUM_W'(v) * SUM_W'(HALF);
   endfunction

   function automatic logic in_band(input logic [SUM_W-1:0] s,
                                    input logic [REG_W-1:0] lo,
                                    input logic [REG_W-1:0] hi);
      return (s > times_half(lo)) && (s < times_half(hi));
   endfunction

   assign dist16   = distance_q[REG_W-1:0];
   assign in_range = !(distance_q < DIST_W'(cfg.valid_min)) &&
                     !(distance_q > DIST_W'(cfg.valid_max));

   // sums as they stand after the shift
   assign older_sh = older_ff - SUM_W'(hist_ff[0]) + SUM_W'(hist_ff[HALF]);
   assign newer_sh = newer_ff - SUM_W'(hist_ff[HISTORY_DEPTH-HALF]) + SUM_W'(dist16);
   assign fill_sum = times_half(dist16);

   assign enter = in_band(older_sh, cfg.far_low, cfg.far_high) &&
                  in_band(newer_sh, cfg.near_low, cfg.near_high);
   assign leave_shift = in_band(newer_sh, cfg.far_low, cfg.far_high) &&
                        in_band(older_sh, cfg.near_low, cfg.near_high);
   // after an entry both halves hold the sample
   assign leave_fill = in_band(fill_sum, cfg.far_low, cfg.far_high) &&
                       in_band(fill_sum, cfg.near_low, cfg.near_high);
   assign leave = enter ? leave_fill : leave_shift;

   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
         hist_in[i] = hist_ff[i+1];
      end
      hist_in[HISTORY_DEPTH-1] = dist16;
      older_in = older_sh;
      newer_in = newer_sh;
      occ_mid  = occ_ff;
      occ_in   = occ_ff;
      ev       = EV_NONE;
      if (!in_range) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_in[i] = cfg.refill_value;
         end
         older_in = times_half(cfg.refill_value);
         newer_in = times_half(cfg.refill_value);
         ev       = EV_RANGE;
      end else begin
         if (enter) begin
            occ_mid = (occ_ff == OCC_MAX) ? occ_ff : occ_ff + 16'sd1;
            ev      = EV_ENTER;
         end
         occ_in = occ_mid;
         if (leave) begin
            occ_in = (occ_mid == OCC_MIN) ? occ_mid : occ_mid - 16'sd1;
            ev     = EV_LEFT;
         end
         if (enter || leave) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = dist16;
            end
            older_in = fill_sum;
            newer_in = fill_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= HIST_RESET;
         end
         older_ff <= times_half(HIST_RESET);
         newer_ff <= times_half(HIST_RESET);
         occ_ff   <= '0;
      end else if (fire) begin
         hist_ff  <= hist_in;
         older_ff <= older_in;
         newer_ff <= newer_in;
         occ_ff   <= occ_in;
      end
   end

   assign result.people_count = occ_in;
   assign result.event_res    = ev;
   assign result.distance_q   = distance_q;

endmodule
